FILE: design/ibm_pkg.sv
// ----------------------------------------------------------------------------
// ibm_pkg
// Shared widths, stage payload types and step functions for the
// inelastic body merge pipeline.
// ----------------------------------------------------------------------------
package ibm_pkg;

  localparam int MASS_W      = 31;
  localparam int VEL_W       = 24;
  localparam int RAD_W       = 16;
  localparam int CNT_W       = 16;
  localparam int SUM_W       = 32;  // mass sum / divisor
  localparam int NUM_W       = 56;  // signed momentum sum
  localparam int ROOT_W      = 17;
  localparam int CUBE_W      = 51;  // radius cube sum, padded to 3-bit groups
  localparam int CREM_W      = 40;  // cube root partial remainder
  localparam int DIV_STEPS   = 24;  // one quotient bit per stage
  localparam int ROOT_STEPS  = 17;  // one root bit per stage
  localparam int FRONT_STG   = 3;
  localparam int NUM_STG     = FRONT_STG + DIV_STEPS + 1;
  localparam int IN_W        = 224;
  localparam int OUT_W       = 120;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // One axis of the restoring divider: remainder, dividend bits still to
  // shift in (quotient bits shift in at the bottom), sign of the numerator.
  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [VEL_W-1:0] low;
    logic             neg;
  } div_t;

  // Payload carried through every iteration stage.
  typedef struct packed {
    div_t              dx;
    div_t              dy;
    logic [SUM_W-1:0]  total;
    logic [CUBE_W-1:0] s;
    logic [CREM_W-1:0] r;
    logic [ROOT_W-1:0] y;
    logic [2*ROOT_W-1:0] y2;
    logic [CNT_W-1:0]  count;
    logic              surv;
  } iter_t;

  // One restoring division step.
  function automatic div_t div_step(div_t d, logic [SUM_W-1:0] total);
    div_t       o;
    logic [SUM_W:0] r1;
    logic       qb;
    r1 = {d.rem, d.low[VEL_W-1]};
    qb = (r1 >= {1'b0, total});
    o.rem = qb ? SUM_W'(r1 - {1'b0, total}) : r1[SUM_W-1:0];
    o.low = {d.low[VEL_W-2:0], qb};
    o.neg = d.neg;
    return o;
  endfunction

endpackage

FILE: design/ibm_front.sv
// ----------------------------------------------------------------------------
// ibm_front
// Three register stages: products, sums and cubes, then sign/magnitude
// split that seeds the divider and cube root iterations.
// ----------------------------------------------------------------------------
module ibm_front import ibm_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STG-1:0]    en,
  input  logic [MASS_W-1:0]       mass_a,
  input  logic [MASS_W-1:0]       mass_b,
  input  logic signed [VEL_W-1:0] vel_a_x,
  input  logic signed [VEL_W-1:0] vel_a_y,
  input  logic signed [VEL_W-1:0] vel_b_x,
  input  logic signed [VEL_W-1:0] vel_b_y,
  input  logic [RAD_W-1:0]        radius_a,
  input  logic [RAD_W-1:0]        radius_b,
  input  logic [CNT_W-1:0]        count_a,
  input  logic [CNT_W-1:0]        count_b,
  output iter_t                   q
);

  // stage 1 registers
  logic signed [NUM_W-1:0] p_ax, p_ay, p_bx, p_by;
  logic [2*RAD_W-1:0]      ra2, rb2;
  logic [RAD_W-1:0]        ra1, rb1;
  logic [SUM_W-1:0]        total1, total2;
  logic [CNT_W-1:0]        cnt1, cnt2;
  logic                    surv1, surv2;
  // stage 2 registers
  logic signed [NUM_W-1:0] num_x, num_y;
  logic [3*RAD_W-1:0]      ra3, rb3;

  logic [CNT_W:0]          cnt_sum;
  logic [CUBE_W-1:0]       cube_sum;
  logic [NUM_W-1:0]        abs_x, abs_y;

  assign cnt_sum = {1'b0, count_a} + {1'b0, count_b} + (CNT_W+1)'(1);

  // stage 1: momentum products, squares, mass sum, count
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_ax   <= NUM_W'($signed(vel_a_x)) * NUM_W'($signed({1'b0, mass_a}));
      p_bx   <= NUM_W'($signed(vel_b_x)) * NUM_W'($signed({1'b0, mass_b}));
      p_ay   <= NUM_W'($signed(vel_a_y)) * NUM_W'($signed({1'b0, mass_a}));
      p_by   <= NUM_W'($signed(vel_b_y)) * NUM_W'($signed({1'b0, mass_b}));
      ra2    <= (2*RAD_W)'(radius_a) * (2*RAD_W)'(radius_a);
      rb2    <= (2*RAD_W)'(radius_b) * (2*RAD_W)'(radius_b);
      ra1    <= radius_a;
      rb1    <= radius_b;
      total1 <= {1'b0, mass_a} + {1'b0, mass_b};
      cnt1   <= cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
      surv1  <= (mass_a >= mass_b);
    end
  end

  // stage 2: momentum sums, cubes
  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_x  <= p_ax + p_bx;
      num_y  <= p_ay + p_by;
      ra3    <= (3*RAD_W)'(ra2) * (3*RAD_W)'(ra1);
      rb3    <= (3*RAD_W)'(rb2) * (3*RAD_W)'(rb1);
      total2 <= total1;
      cnt2   <= cnt1;
      surv2  <= surv1;
    end
  end

  // stage 3: magnitudes and seeds for the iterations
  assign abs_x    = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
  assign abs_y    = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
  assign cube_sum = CUBE_W'(ra3) + CUBE_W'(rb3);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q.dx.rem <= abs_x[NUM_W-1:VEL_W];
      q.dx.low <= abs_x[VEL_W-1:0];
      q.dx.neg <= num_x[NUM_W-1];
      q.dy.rem <= abs_y[NUM_W-1:VEL_W];
      q.dy.low <= abs_y[VEL_W-1:0];
      q.dy.neg <= num_y[NUM_W-1];
      q.total  <= total2;
      q.s      <= cube_sum;
      q.r      <= '0;
      q.y      <= '0;
      q.y2     <= '0;
      q.count  <= cnt2;
      q.surv   <= surv2;
    end
  end

endmodule

FILE: design/ibm_iter.sv
// ----------------------------------------------------------------------------
// ibm_iter
// One pipeline stage: one quotient bit per axis and, where enabled, one
// bit of the integer cube root (digit method with running square).
// ----------------------------------------------------------------------------
module ibm_iter import ibm_pkg::*; #(
  parameter bit ROOT_ON = 1'b1
) (
  input  logic  clk,
  input  logic  en,
  input  iter_t d,
  output iter_t q
);

  iter_t               nxt;
  logic [ROOT_W-1:0]   y1;
  logic [2*ROOT_W-1:0] y2s;
  logic [CREM_W-1:0]   r1, t;
  logic                take;

  // root step: y' = 2y, test (y'+1)^3 - y'^3 = 3y'^2 + 3y' + 1
  assign y1   = {d.y[ROOT_W-2:0], 1'b0};
  assign y2s  = {d.y2[2*ROOT_W-3:0], 2'b00};
  assign r1   = {d.r[CREM_W-4:0], d.s[CUBE_W-1 -: 3]};
  assign t    = CREM_W'(y2s) + CREM_W'({y2s, 1'b0}) + CREM_W'(y1)
              + CREM_W'({y1, 1'b0}) + CREM_W'(1);
  assign take = (r1 >= t);

  always_comb begin
    nxt    = d;
    nxt.dx = div_step(d.dx, d.total);
    nxt.dy = div_step(d.dy, d.total);
    if (ROOT_ON) begin
      nxt.s  = {d.s[CUBE_W-4:0], 3'b000};
      nxt.r  = take ? r1 - t : r1;
      nxt.y  = take ? y1 + ROOT_W'(1) : y1;
      nxt.y2 = take ? y2s + (2*ROOT_W)'({y1, 1'b0}) + (2*ROOT_W)'(1) : y2s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

FILE: design/inelastic_body_merge_unit.sv
// ----------------------------------------------------------------------------
// inelastic_body_merge_unit
// Perfectly inelastic merge of two 2D bodies: mass sum, momentum-weighted
// velocity, cube-root radius, saturating merge count and survivor flag.
// ----------------------------------------------------------------------------
// Fully pipelined: one request enters per cycle unless back-pressure stalls
// the input. Each result passes 3 front stages for products, sums and
// cubes, 24 restoring divider stages of one quotient bit each that also
// carry the 17 cube-root digit steps, and one output register. Each stage
// holds when the stage after it is full and stalled, so empty stages fill
// up under back-pressure and nothing is dropped or repeated.
module inelastic_body_merge_unit import ibm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // mass_a[30:0] mass_b[61:31] vel_a_x[85:62] vel_a_y[109:86]
  // vel_b_x[133:110] vel_b_y[157:134] radius_a[173:158] radius_b[189:174]
  // count_a[205:190] count_b[221:206], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // merged_mass[31:0] merged_vel_x[55:32] merged_vel_y[79:56]
  // merged_radius[96:80] merged_count[112:97] survivor_is_a[113], zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic [NUM_STG-1:0] vld;
  logic [NUM_STG-1:0] rdy;
  iter_t              stg [DIV_STEPS+1];

  // per-stage ready: a stage loads when empty or when its successor moves
  assign rdy[NUM_STG-1] = !vld[NUM_STG-1] || m_axis_tready;
  for (genvar i = 0; i < NUM_STG-1; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NUM_STG-1];

  // front: products, sums, cubes
  ibm_front u_front (
    .clk      (clk),
    .en       (rdy[FRONT_STG-1:0]),
    .mass_a   (s_axis_tdata[30:0]),
    .mass_b   (s_axis_tdata[61:31]),
    .vel_a_x  (s_axis_tdata[85:62]),
    .vel_a_y  (s_axis_tdata[109:86]),
    .vel_b_x  (s_axis_tdata[133:110]),
    .vel_b_y  (s_axis_tdata[157:134]),
    .radius_a (s_axis_tdata[173:158]),
    .radius_b (s_axis_tdata[189:174]),
    .count_a  (s_axis_tdata[205:190]),
    .count_b  (s_axis_tdata[221:206]),
    .q        (stg[0])
  );

  // divider / cube root iterations
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_iter
    ibm_iter #(.ROOT_ON(k < ROOT_STEPS)) u_iter (
      .clk (clk),
      .en  (rdy[FRONT_STG+k]),
      .d   (stg[k]),
      .q   (stg[k+1])
    );
  end

  // output register: apply signs, zero velocity for zero total mass
  iter_t            fin;
  logic [VEL_W-1:0] vx, vy;

  assign fin = stg[DIV_STEPS];
  assign vx  = (fin.total == '0) ? '0
             : (fin.dx.neg ? VEL_W'(~fin.dx.low + VEL_W'(1)) : fin.dx.low);
  assign vy  = (fin.total == '0) ? '0
             : (fin.dy.neg ? VEL_W'(~fin.dy.low + VEL_W'(1)) : fin.dy.low);

  always_ff @(posedge clk) begin
    if (rdy[NUM_STG-1]) begin
      m_axis_tdata <= {6'b0, fin.surv, fin.count, fin.y, vy, vx, fin.total};
    end
  end

`ifndef SYNTHESIS
  // input stalls only when every stage holds a request
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> &vld)
    else $error("input stalled with an empty pipeline stage");

  // zero total mass gives zero velocity
  a_zero_mass: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[31:0] == 32'd0) |-> m_axis_tdata[79:32] == 48'd0)
    else $error("nonzero velocity for zero mass");

  // merge count is at least one
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[112:97] != 16'd0)
    else $error("merge count is zero");

  // radius bounded by the cube root of twice the largest cube
  a_radius: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[96:80] <= 17'd82570)
    else $error("merged radius out of range");
`endif

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for inelastic_body_merge_unit. Drives collision
// requests with random gaps, stalls the result side at random, predicts
// each merged body and checks every result field in request order.
// ----------------------------------------------------------------------------
module testbench;
  import ibm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CNT_W-1:0]  cb;
    logic [CNT_W-1:0]  ca;
    logic [RAD_W-1:0]  rb;
    logic [RAD_W-1:0]  ra;
    logic [VEL_W-1:0]  vby;
    logic [VEL_W-1:0]  vbx;
    logic [VEL_W-1:0]  vay;
    logic [VEL_W-1:0]  vax;
    logic [MASS_W-1:0] mb;
    logic [MASS_W-1:0] ma;
  } pair_t;

  typedef struct packed {
    logic              surv;
    logic [CNT_W-1:0]  count;
    logic [ROOT_W-1:0] radius;
    logic [VEL_W-1:0]  vy;
    logic [VEL_W-1:0]  vx;
    logic [SUM_W-1:0]  mass;
  } merged_t;

  // Momentum-weighted mean, truncated toward zero.
  function automatic logic [VEL_W-1:0] mean_vel(logic signed [VEL_W-1:0] va,
      logic signed [VEL_W-1:0] vb, longint ma, longint mb);
    longint num;
    longint q;
    if (ma + mb == 0) return '0;
    num = longint'(va) * ma + longint'(vb) * mb;
    q = num / (ma + mb);
    return q[VEL_W-1:0];
  endfunction

  function automatic logic [ROOT_W-1:0] cube_root(longint s);
    longint root;
    longint cand;
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand * cand <= s) root = cand;
    end
    return root[ROOT_W-1:0];
  endfunction

  function automatic merged_t predict_merge(pair_t p);
    merged_t m;
    longint ma, mb, ra, rb, cnt;
    ma = longint'(p.ma); mb = longint'(p.mb);
    ra = longint'(p.ra); rb = longint'(p.rb);
    cnt = longint'(p.ca) + longint'(p.cb) + 1;
    m.mass   = SUM_W'(ma + mb);
    m.vx     = mean_vel(p.vax, p.vbx, ma, mb);
    m.vy     = mean_vel(p.vay, p.vby, ma, mb);
    m.radius = cube_root(ra * ra * ra + rb * rb * rb);
    m.count  = (cnt > 65535) ? CNT_MAX : CNT_W'(cnt);
    m.surv   = (ma >= mb);
    return m;
  endfunction

  class merge_scoreboard;
    merged_t pending[$];
    int      errors;

    function void note_request(pair_t p);
      pending.push_back(predict_merge(p));
    endfunction

    function void check_result(merged_t got);
      merged_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got, got);
        return;
      end
      want = pending.pop_front();
      if (got.mass !== want.mass)     report("merged_mass", want, got);
      if (got.vx !== want.vx)         report("merged_vel_x", want, got);
      if (got.vy !== want.vy)         report("merged_vel_y", want, got);
      if (got.radius !== want.radius) report("merged_radius", want, got);
      if (got.count !== want.count)   report("merged_count", want, got);
      if (got.surv !== want.surv)     report("survivor_is_a", want, got);
    endfunction

    function void report(string what, merged_t want, merged_t got);
      errors++;
      if (errors <= 10)
        $display("MISMATCH %s: expected %h actual %h", what, want, got);
    endfunction
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             s_axis_tvalid = 0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;

  merge_scoreboard sb = new();
  int  phase_quiet = 0;   // no idling near the end
  int  hold_off = 0;      // long receiver stall request
  longint cycles = 0;

  inelastic_body_merge_unit u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Result side: checks each accepted result; random stalls, long hold-off on request.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(merged_t'(m_axis_tdata[$bits(merged_t)-1:0]));
  end

  initial begin
    int n;
    repeat (4) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        m_axis_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if (!phase_quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end else begin
        m_axis_tready <= 1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (cycles > 400000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One request; holds tvalid until accepted. Optional random gap before.
  task automatic send_pair(pair_t p);
    int gap;
    if (!phase_quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= IN_W'(p);
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(p);
  endtask

  function automatic logic [31:0] pick_bits(int w);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = '1;
      2: v = $urandom_range(0, 15);
      3: v = 32'h1 << $urandom_range(0, w - 1);
      default: v = $urandom;
    endcase
    return 32'(v & ((64'h1 << w) - 1));
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    p.ma  = MASS_W'(pick_bits(MASS_W));
    p.mb  = ($urandom_range(0, 7) == 0) ? p.ma : MASS_W'(pick_bits(MASS_W));
    p.vax = VEL_W'(pick_bits(VEL_W));
    p.vay = VEL_W'(pick_bits(VEL_W));
    p.vbx = VEL_W'(pick_bits(VEL_W));
    p.vby = VEL_W'(pick_bits(VEL_W));
    p.ra  = RAD_W'(pick_bits(RAD_W));
    p.rb  = RAD_W'(pick_bits(RAD_W));
    p.ca  = CNT_W'(pick_bits(CNT_W));
    p.cb  = CNT_W'(pick_bits(CNT_W));
    return p;
  endfunction

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    pair_t p;
    pair_t dir[$];
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: zero masses, extremes, ties, count saturation.
    p = '0; dir.push_back(p);
    p.vax = 24'h7FFFFF; p.vbx = 24'h800000; p.vay = 24'h800000; p.vby = 24'h7FFFFF;
    dir.push_back(p);                                 // both masses zero
    p.ma = '1; p.mb = '1; dir.push_back(p);           // max masses, tie
    p.ma = 31'd1; p.mb = '1; dir.push_back(p);
    p.ma = '1; p.mb = 31'd0; dir.push_back(p);
    p.ma = 31'd3; p.mb = 31'd4; p.vax = 24'hFFFFFF; p.vbx = 24'h000001;
    p.vay = 24'hFFFFFE; p.vby = 24'h000000; dir.push_back(p);   // trunc to zero
    p.ra = '1; p.rb = '1; p.ca = '1; p.cb = '1; dir.push_back(p);
    p.ra = 16'd1; p.rb = 16'd0; p.ca = 16'hFFFE; p.cb = 16'd0; dir.push_back(p);
    p.ra = 16'd0; p.rb = '1; p.ca = 16'h7FFF; p.cb = 16'h8000; dir.push_back(p);
    p.ra = 16'd3; p.rb = 16'd4; p.ca = 16'h8000; p.cb = 16'h8000; dir.push_back(p);
    p.ra = 16'd6; p.rb = 16'd8; dir.push_back(p);
    foreach (dir[i]) send_pair(dir[i]);

    // Pause until every result is back.
    drain();

    // Random, with a long receiver stall partway through.
    for (int i = 0; i < 780; i++) begin
      if (i == 200) hold_off = 300;
      if (i == 700) phase_quiet = 1;
      send_pair(random_pair());
    end
    drain();
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
